// ===== hdl/tss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Types and codes shared by the table step sequencer and its checker.
// ----------------------------------------------------------------------------
package tss_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_OPENING  = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_FINISHED = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_LOAD      = 3'd1,
        KIND_START     = 3'd2,
        KIND_PAUSE     = 3'd3,
        KIND_UNPAUSE   = 3'd4,
        KIND_HALT      = 3'd5,
        KIND_SET_CYCLE = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        CFG_FIRST_STEP_TIME   = 3'd0,
        CFG_HAS_OPENING       = 3'd1,
        CFG_OPENING_CYCLE_ADD = 3'd2,
        CFG_MAIN_LINE_COUNT   = 3'd3,
        CFG_OPEN_LINE_COUNT   = 3'd4,
        CFG_MAIN_KEEP         = 3'd5,
        CFG_OPEN_KEEP         = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        EV_STEP = 2'd0,
        EV_LINE = 2'd1,
        EV_HALT = 2'd2
    } ev_t;

    // result sequences one item can cause
    typedef enum logic [1:0] {
        PAT_STEP_LINE      = 2'd0,
        PAT_STEP_HALT      = 2'd1,
        PAT_STEP_HALT_STEP = 2'd2,
        PAT_HALT           = 2'd3
    } pat_t;

    typedef struct packed {
        logic [15:0] gpio;
        logic [15:0] heat0;
        logic [15:0] heat1;
        logic [15:0] heat2;
        logic [15:0] heat3;
        logic [15:0] heat4;
        logic [15:0] duration;
        logic [7:0]  sound;
        logic [7:0]  audio;
    } line_t;

endpackage

// ===== hdl/table_step_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_step_sequencer_unit
// Tick-driven step sequencer playing an opening and a main line table held
// in one synchronous RAM.
// ----------------------------------------------------------------------------
// Path: result beats of an item pass the job stage, then the output register.
// Throughput: one item per cycle while in_stall is low; an item with results holds
//   the path until its last result beat (1 to 3) leaves the single output register.
// The line read for a step end is forwarded from the RAM read port to the next
//   item, so ticks may follow each other in consecutive cycles.
// Reset: control state and configuration reset at once (line counts to 1);
//   the line table is undefined until loaded and has no clearing pass.
module table_step_sequencer_unit #(
    parameter int LINES_PER_TABLE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [5:0]  line_address,
    input  logic [15:0] line_gpio,
    input  logic [15:0] line_heat0,
    input  logic [15:0] line_heat1,
    input  logic [15:0] line_heat2,
    input  logic [15:0] line_heat3,
    input  logic [15:0] line_heat4,
    input  logic [15:0] line_duration,
    input  logic [7:0]  line_sound,
    input  logic [7:0]  line_audio,
    input  logic [15:0] cycle_value,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [15:0] cycles_left,
    output logic [15:0] drive_gpio,
    output logic [15:0] drive_heat0,
    output logic [15:0] drive_heat1,
    output logic [15:0] drive_heat2,
    output logic [15:0] drive_heat3,
    output logic [15:0] drive_heat4,
    output logic [7:0]  play_sound,
    output logic [7:0]  play_audio,
    output logic        last
);

    localparam int IW    = $clog2(LINES_PER_TABLE);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int CW    = ((IW > 6) ? IW : 6) + 2;
    localparam int LW    = $bits(tss_pkg::line_t);

    // configuration
    logic [15:0] first_step_reg;
    logic        has_opening_reg;
    logic [15:0] open_add_reg;
    logic [5:0]  main_count_reg;
    logic [5:0]  open_count_reg;
    logic        main_keep_reg;
    logic        open_keep_reg;

    // sequencer state
    tss_pkg::mode_t mode_reg, mode_next;
    logic           paused_reg, paused_next;
    logic [IW-1:0]  line_idx_reg, line_idx_next;
    logic [15:0]    step_reg, step_next;
    logic           step_in_ram_reg, step_in_ram_next;
    logic [15:0]    cycle_reg, cycle_next;

    // job stage and output stage
    logic           d1_valid_reg;
    tss_pkg::pat_t  d1_pat_reg;
    logic [15:0]    d1_cycles_reg;
    logic           out_valid_reg;
    tss_pkg::pat_t  out_pat_reg;
    logic [1:0]     out_beat_reg;
    logic [15:0]    out_cycles_reg;
    tss_pkg::line_t out_line_reg;

    // RAM
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    tss_pkg::line_t ram_wline;
    logic [LW-1:0]  ram_rdata;
    tss_pkg::line_t ram_line;

    logic           in_accept, out_accept, d1_move, out_last;
    logic           job_new;
    tss_pkg::pat_t  job_pat;
    tss_pkg::ev_t   out_event;

    // tick helpers
    logic           run_opening;
    logic [5:0]     raw_count;
    logic [CW-1:0]  line_count, seq_w, load_idx;
    logic           keep;
    logic [15:0]    eff_step, step_dec, cycle_dec;
    logic           table_wrap;

    assign cfg_ready  = 1'b1;
    assign ram_line   = tss_pkg::line_t'(ram_rdata);

    assign out_accept = out_valid_reg && !out_stall;
    assign d1_move    = d1_valid_reg && (!out_valid_reg || (out_accept && out_last));
    assign in_stall   = d1_valid_reg && !d1_move;
    assign in_accept  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_step_reg  <= '0;
            has_opening_reg <= 1'b0;
            open_add_reg    <= '0;
            main_count_reg  <= 6'd1;
            open_count_reg  <= 6'd1;
            main_keep_reg   <= 1'b0;
            open_keep_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (tss_pkg::cfg_idx_t'(cfg_index))
                tss_pkg::CFG_FIRST_STEP_TIME:   first_step_reg  <= cfg_data;
                tss_pkg::CFG_HAS_OPENING:       has_opening_reg <= cfg_data[0];
                tss_pkg::CFG_OPENING_CYCLE_ADD: open_add_reg    <= cfg_data;
                tss_pkg::CFG_MAIN_LINE_COUNT:   main_count_reg  <= cfg_data[5:0];
                tss_pkg::CFG_OPEN_LINE_COUNT:   open_count_reg  <= cfg_data[5:0];
                tss_pkg::CFG_MAIN_KEEP:         main_keep_reg   <= cfg_data[0];
                tss_pkg::CFG_OPEN_KEEP:         open_keep_reg   <= cfg_data[0];
                default:                        ;
            endcase
        end
    end

    // tick arithmetic; step count lives in the RAM read data right after a line read
    always_comb
    begin
        run_opening = (mode_reg == tss_pkg::MODE_OPENING);
        raw_count   = run_opening ? open_count_reg : main_count_reg;
        keep        = run_opening ? open_keep_reg : main_keep_reg;
        if (raw_count == 6'd0)
        begin
            line_count = CW'(1);
        end
        else if (CW'(raw_count) > CW'(LINES_PER_TABLE))
        begin
            line_count = CW'(LINES_PER_TABLE);
        end
        else
        begin
            line_count = CW'(raw_count);
        end
        eff_step   = step_in_ram_reg ? ram_line.duration : step_reg;
        step_dec   = (eff_step != 16'd0) ? eff_step - 16'd1 : 16'd0;
        cycle_dec  = (cycle_reg != 16'd0) ? cycle_reg - 16'd1 : 16'd0;
        seq_w      = CW'(line_idx_reg) + CW'(1);
        table_wrap = (seq_w + CW'(1)) >= line_count;
        load_idx   = CW'(line_address[4:0]);
    end

    // next state
    always_comb
    begin
        mode_next        = mode_reg;
        paused_next      = paused_reg;
        line_idx_next    = line_idx_reg;
        step_next        = step_reg;
        step_in_ram_next = step_in_ram_reg;
        cycle_next       = cycle_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_waddr        = {line_address[5], load_idx[IW-1:0]};
        ram_raddr        = '0;
        job_new          = 1'b0;
        job_pat          = tss_pkg::PAT_HALT;
        ram_wline.gpio     = line_gpio;
        ram_wline.heat0    = line_heat0;
        ram_wline.heat1    = line_heat1;
        ram_wline.heat2    = line_heat2;
        ram_wline.heat3    = line_heat3;
        ram_wline.heat4    = line_heat4;
        ram_wline.duration = line_duration;
        ram_wline.sound    = line_sound;
        ram_wline.audio    = line_audio;
        if (in_accept)
        begin
            case (tss_pkg::kind_t'(kind))
                tss_pkg::KIND_TICK:
                begin
                    if (!paused_reg && (mode_reg == tss_pkg::MODE_OPENING ||
                                        mode_reg == tss_pkg::MODE_RUNNING))
                    begin
                        step_next        = step_dec;
                        step_in_ram_next = 1'b0;
                        if (step_dec == 16'd0)
                        begin
                            cycle_next = cycle_dec;
                            job_new    = 1'b1;
                            if (cycle_dec == 16'd0 && !keep)
                            begin
                                mode_next     = tss_pkg::MODE_FINISHED;
                                line_idx_next = '0;
                                paused_next   = 1'b0;
                                job_pat       = tss_pkg::PAT_STEP_HALT;
                            end
                            else if (table_wrap && cycle_dec == 16'd0)
                            begin
                                mode_next     = tss_pkg::MODE_FINISHED;
                                line_idx_next = '0;
                                paused_next   = 1'b0;
                                job_pat       = tss_pkg::PAT_STEP_HALT_STEP;
                            end
                            else
                            begin
                                if (table_wrap)
                                begin
                                    mode_next     = tss_pkg::MODE_RUNNING;
                                    line_idx_next = '0;
                                end
                                else
                                begin
                                    line_idx_next = seq_w[IW-1:0];
                                end
                                ram_re           = 1'b1;
                                ram_raddr        = {run_opening && !table_wrap, line_idx_next};
                                step_in_ram_next = 1'b1;
                                job_pat          = tss_pkg::PAT_STEP_LINE;
                            end
                        end
                    end
                end
                tss_pkg::KIND_LOAD:
                begin
                    ram_we = (load_idx < CW'(LINES_PER_TABLE));
                end
                tss_pkg::KIND_START:
                begin
                    step_next        = first_step_reg;
                    step_in_ram_next = 1'b0;
                    paused_next      = 1'b0;
                    line_idx_next    = '0;
                    if (has_opening_reg)
                    begin
                        cycle_next = cycle_reg + open_add_reg;
                        mode_next  = tss_pkg::MODE_OPENING;
                    end
                    else
                    begin
                        mode_next = tss_pkg::MODE_RUNNING;
                    end
                end
                tss_pkg::KIND_PAUSE:
                begin
                    paused_next = 1'b1;
                end
                tss_pkg::KIND_UNPAUSE:
                begin
                    paused_next = 1'b0;
                end
                tss_pkg::KIND_HALT:
                begin
                    cycle_next    = '0;
                    mode_next     = tss_pkg::MODE_FINISHED;
                    line_idx_next = '0;
                    paused_next   = 1'b0;
                    job_new       = 1'b1;
                    job_pat       = tss_pkg::PAT_HALT;
                end
                tss_pkg::KIND_SET_CYCLE:
                begin
                    cycle_next = cycle_value;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= tss_pkg::MODE_IDLE;
            paused_reg      <= 1'b0;
            line_idx_reg    <= '0;
            step_reg        <= '0;
            step_in_ram_reg <= 1'b0;
            cycle_reg       <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            paused_reg      <= paused_next;
            line_idx_reg    <= line_idx_next;
            step_reg        <= step_next;
            step_in_ram_reg <= step_in_ram_next;
            cycle_reg       <= cycle_next;
        end
    end

    tss_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wline),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // job stage: holds an item until the output register takes it with the line read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
        end
        else if (job_new)
        begin
            d1_valid_reg <= 1'b1;
        end
        else if (d1_move)
        begin
            d1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_new)
        begin
            d1_pat_reg    <= job_pat;
            d1_cycles_reg <= cycle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_beat_reg  <= '0;
        end
        else if (d1_move)
        begin
            out_valid_reg <= 1'b1;
            out_beat_reg  <= '0;
        end
        else if (out_accept)
        begin
            if (out_last)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_beat_reg <= out_beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d1_move)
        begin
            out_pat_reg    <= d1_pat_reg;
            out_cycles_reg <= d1_cycles_reg;
            out_line_reg   <= ram_line;
        end
    end

    // beat decode
    always_comb
    begin
        out_event = tss_pkg::EV_STEP;
        out_last  = 1'b0;
        case (out_pat_reg)
            tss_pkg::PAT_STEP_LINE:
            begin
                out_event = (out_beat_reg == 2'd0) ? tss_pkg::EV_STEP : tss_pkg::EV_LINE;
                out_last  = (out_beat_reg != 2'd0);
            end
            tss_pkg::PAT_STEP_HALT:
            begin
                out_event = (out_beat_reg == 2'd0) ? tss_pkg::EV_STEP : tss_pkg::EV_HALT;
                out_last  = (out_beat_reg != 2'd0);
            end
            tss_pkg::PAT_STEP_HALT_STEP:
            begin
                out_event = (out_beat_reg == 2'd1) ? tss_pkg::EV_HALT : tss_pkg::EV_STEP;
                out_last  = (out_beat_reg == 2'd2);
            end
            tss_pkg::PAT_HALT:
            begin
                out_event = tss_pkg::EV_HALT;
                out_last  = 1'b1;
            end
            default:
            begin
                out_event = tss_pkg::EV_HALT;
                out_last  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid   = out_valid_reg;
        event_res   = out_event;
        cycles_left = out_cycles_reg;
        last        = out_last;
        if (out_event == tss_pkg::EV_LINE)
        begin
            drive_gpio  = out_line_reg.gpio;
            drive_heat0 = out_line_reg.heat0;
            drive_heat1 = out_line_reg.heat1;
            drive_heat2 = out_line_reg.heat2;
            drive_heat3 = out_line_reg.heat3;
            drive_heat4 = out_line_reg.heat4;
            play_sound  = out_line_reg.sound;
            play_audio  = out_line_reg.audio;
        end
        else
        begin
            drive_gpio  = '0;
            drive_heat0 = '0;
            drive_heat1 = '0;
            drive_heat2 = '0;
            drive_heat3 = '0;
            drive_heat4 = '0;
            play_sound  = '0;
            play_audio  = '0;
        end
    end

endmodule

// ===== hdl/tss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tss_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/tss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks on the result channel of the table step sequencer.
// ----------------------------------------------------------------------------
module tss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  event_res,
    input logic [15:0] cycles_left,
    input logic [15:0] drive_gpio,
    input logic [15:0] drive_heat0,
    input logic [7:0]  play_sound,
    input logic [7:0]  play_audio,
    input logic        last
);

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(cycles_left)
            && $stable(last))
        else $error("stalled result beat changed");

    // beats of one item come without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a multi-beat result");

    // an applied line always ends its item's results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == tss_pkg::EV_LINE |-> last)
        else $error("line beat not last");

    // halt clears the drives (gpio, heat0, sound and audio checked)
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == tss_pkg::EV_HALT |->
            drive_gpio == 16'd0 && drive_heat0 == 16'd0 && play_sound == 8'd0
            && play_audio == 8'd0)
        else $error("halt beat with drives set");

endmodule

bind table_step_sequencer_unit tss_checker u_tss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .cycles_left (cycles_left),
    .drive_gpio  (drive_gpio),
    .drive_heat0 (drive_heat0),
    .play_sound  (play_sound),
    .play_audio  (play_audio),
    .last        (last)
);
